// ----- hw/rtl/sfcs_pkg.sv -----
// Shared types, constants and helpers of the SPI flash command sequencer.
package sfcs_pkg;

	// Flash geometry. PAGE_BYTES is a power of two.
	localparam int PAGE_BYTES = 256;
	localparam int ADDR_BITS  = 24;
	localparam int ADDR_BYTES = (ADDR_BITS + 7) / 8;
	localparam int PAGE_W     = $clog2(PAGE_BYTES + 1);
	localparam int CNT_W      = 25;
	localparam int FADDR_W    = 24;

	typedef logic [ADDR_BITS-1:0]    addr_t;
	typedef logic [ADDR_BYTES*8-1:0] addr_pad_t;

	// Flash opcodes
	localparam logic [7:0] CMD_READ_ID = 8'h9F;
	localparam logic [7:0] CMD_READ    = 8'h03;
	localparam logic [7:0] CMD_WREN    = 8'h06;
	localparam logic [7:0] CMD_PROGRAM = 8'h02;
	localparam logic [7:0] CMD_ERASE   = 8'hC7;
	localparam logic [7:0] CMD_RDSR    = 8'h05;
	localparam int         SR_WIP_BIT  = 0;

	localparam logic [2:0] BIT_MSB = 3'd7;

	// Item kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// Commands
	localparam logic [1:0] OP_READ_ID = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_PROGRAM = 2'd2;
	localparam logic [1:0] OP_ERASE   = 2'd3;

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_HDR   = 6'b000010,
		PH_TX    = 6'b000100,
		PH_WAIT  = 6'b001000,
		PH_RX    = 6'b010000,
		PH_DESEL = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		FR_ID    = 3'd0,
		FR_READ  = 3'd1,
		FR_WREN  = 3'd2,
		FR_PROG  = 3'd3,
		FR_ERASE = 3'd4,
		FR_POLL  = 3'd5
	} frame_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         op;
		logic [FADDR_W-1:0] flash_address;
		logic [CNT_W-1:0]   byte_count;
		logic [7:0]         write_byte;
		logic               miso;
	} sfcs_item_t;

	typedef struct packed {
		logic       sck;
		logic       mosi;
		logic       cs_n;
		logic       read_valid;
		logic [7:0] read_data;
		logic       need_data;
		logic       busy_res;
		logic       done_res;
		logic       cmd_error;
	} sfcs_res_t;

	function automatic logic [2:0] hdr_len(frame_t f);
		logic [2:0] n;
		n = 3'd1;
		if (f == FR_READ || f == FR_PROG) begin
			n = 3'(1 + ADDR_BYTES);
		end
		return n;
	endfunction

	// Header byte k of a frame: opcode first, then address MSB first.
	function automatic logic [7:0] hdr_byte(frame_t f, logic [2:0] k, addr_t a);
		logic [7:0] b;
		addr_pad_t  pad;
		logic [2:0] sel;
		pad = addr_pad_t'(a);
		sel = 3'(ADDR_BYTES) - k;
		b = 8'(pad >> {sel, 3'b000});
		if (k == 3'd0) begin
			case (f)
				FR_ID:    b = CMD_READ_ID;
				FR_READ:  b = CMD_READ;
				FR_WREN:  b = CMD_WREN;
				FR_PROG:  b = CMD_PROGRAM;
				FR_ERASE: b = CMD_ERASE;
				default:  b = CMD_RDSR;
			endcase
		end
		return b;
	endfunction

endpackage

// ----- hw/rtl/sfcs_seq.sv -----
// Sequencer state and next-state logic: one item in, one result out per fire.
module sfcs_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  sfcs_pkg::sfcs_item_t item,
	output sfcs_pkg::sfcs_res_t  res
);

	sfcs_pkg::phase_t                  phase_q, phase_d;
	sfcs_pkg::frame_t                  frame_q, frame_d, nf;
	logic [1:0]                        op_q, op_d;
	sfcs_pkg::addr_t                   addr_q, addr_d;
	logic [sfcs_pkg::CNT_W-1:0]        left_q, left_d;
	logic [sfcs_pkg::PAGE_W-1:0]       page_q, page_d, room, pdec;
	logic [7:0]                        shreg_q, shreg_d, sh;
	logic [2:0]                        bit_q, bit_d, hnext;
	logic                              half_q, half_d;
	logic [2:0]                        hidx_q, hidx_d;
	logic                              sck_q, sck_d, mosi_q, mosi_d, csn_q, csn_d;
	logic                              new_frame, rvalid, done, err;
	logic [7:0]                        rdata;

	always_comb begin
		phase_d   = phase_q;
		frame_d   = frame_q;
		op_d      = op_q;
		addr_d    = addr_q;
		left_d    = left_q;
		page_d    = page_q;
		shreg_d   = shreg_q;
		bit_d     = bit_q;
		half_d    = half_q;
		hidx_d    = hidx_q;
		sck_d     = sck_q;
		mosi_d    = mosi_q;
		csn_d     = csn_q;
		new_frame = 1'b0;
		nf        = sfcs_pkg::FR_ID;
		rvalid    = 1'b0;
		rdata     = 8'h00;
		done      = 1'b0;
		err       = 1'b0;
		sh        = shreg_q;
		hnext     = hidx_q + 3'd1;
		pdec      = page_q - 1'b1;
		room      = sfcs_pkg::PAGE_W'(sfcs_pkg::PAGE_BYTES
			- int'(addr_q % sfcs_pkg::PAGE_BYTES));

		case (item.kind)
			sfcs_pkg::KIND_START: begin
				if (phase_q != sfcs_pkg::PH_IDLE) begin
					err = 1'b1;
				end else begin
					op_d   = item.op;
					addr_d = sfcs_pkg::addr_t'(item.flash_address);
					left_d = item.byte_count;
					page_d = '0;
					case (item.op)
						sfcs_pkg::OP_READ_ID: begin
							new_frame = 1'b1;
							nf        = sfcs_pkg::FR_ID;
						end
						sfcs_pkg::OP_READ: begin
							new_frame = 1'b1;
							nf        = sfcs_pkg::FR_READ;
						end
						sfcs_pkg::OP_PROGRAM: begin
							if (item.byte_count == '0) begin
								done = 1'b1;
							end else begin
								new_frame = 1'b1;
								nf        = sfcs_pkg::FR_WREN;
							end
						end
						default: begin
							new_frame = 1'b1;
							nf        = sfcs_pkg::FR_WREN;
						end
					endcase
				end
			end
			sfcs_pkg::KIND_DATA: begin
				if (phase_q == sfcs_pkg::PH_WAIT) begin
					shreg_d = item.write_byte;
					bit_d   = sfcs_pkg::BIT_MSB;
					half_d  = 1'b0;
					phase_d = sfcs_pkg::PH_TX;
				end
			end
			sfcs_pkg::KIND_TICK: begin
				if (phase_q == sfcs_pkg::PH_DESEL) begin
					sck_d  = 1'b0;
					mosi_d = 1'b1;
					csn_d  = 1'b1;
					// pick the next frame of the command or finish
					case (frame_q)
						sfcs_pkg::FR_WREN: begin
							new_frame = 1'b1;
							if (op_q == sfcs_pkg::OP_ERASE) begin
								nf = sfcs_pkg::FR_ERASE;
							end else begin
								nf = sfcs_pkg::FR_PROG;
								if (left_q < sfcs_pkg::CNT_W'(room)) begin
									page_d = sfcs_pkg::PAGE_W'(left_q);
								end else begin
									page_d = room;
								end
							end
						end
						sfcs_pkg::FR_PROG, sfcs_pkg::FR_ERASE: begin
							new_frame = 1'b1;
							nf        = sfcs_pkg::FR_POLL;
						end
						sfcs_pkg::FR_POLL: begin
							if (shreg_q[sfcs_pkg::SR_WIP_BIT]) begin
								new_frame = 1'b1;
								nf        = sfcs_pkg::FR_POLL;
							end else if (op_q == sfcs_pkg::OP_PROGRAM && left_q != '0) begin
								new_frame = 1'b1;
								nf        = sfcs_pkg::FR_WREN;
							end else begin
								phase_d = sfcs_pkg::PH_IDLE;
								done    = 1'b1;
							end
						end
						default: begin
							phase_d = sfcs_pkg::PH_IDLE;
							done    = 1'b1;
						end
					endcase
				end else if (phase_q == sfcs_pkg::PH_HDR || phase_q == sfcs_pkg::PH_TX
					|| phase_q == sfcs_pkg::PH_RX) begin
					if (!half_q) begin
						// low half: drive MOSI
						sck_d  = 1'b0;
						csn_d  = 1'b0;
						mosi_d = (phase_q == sfcs_pkg::PH_RX) ? 1'b1 : shreg_q[bit_q];
						half_d = 1'b1;
					end else begin
						// high half: SCK up, sample MISO in the receive phase
						sck_d  = 1'b1;
						csn_d  = 1'b0;
						half_d = 1'b0;
						if (phase_q == sfcs_pkg::PH_RX) begin
							sh = {shreg_q[6:0], item.miso};
						end
						shreg_d = sh;
						if (bit_q != 3'd0) begin
							bit_d = bit_q - 3'd1;
						end else begin
							bit_d  = sfcs_pkg::BIT_MSB;
							mosi_d = 1'b1;
							case (phase_q)
								sfcs_pkg::PH_HDR: begin
									hidx_d = hnext;
									if (hnext < sfcs_pkg::hdr_len(frame_q)) begin
										shreg_d = sfcs_pkg::hdr_byte(frame_q, hnext, addr_q);
									end else if (frame_q == sfcs_pkg::FR_ID
										|| frame_q == sfcs_pkg::FR_POLL) begin
										phase_d = sfcs_pkg::PH_RX;
										shreg_d = 8'h00;
									end else if (frame_q == sfcs_pkg::FR_READ) begin
										phase_d = (left_q == '0) ? sfcs_pkg::PH_DESEL
											: sfcs_pkg::PH_RX;
										shreg_d = 8'h00;
									end else if (frame_q == sfcs_pkg::FR_PROG) begin
										phase_d = sfcs_pkg::PH_WAIT;
									end else begin
										phase_d = sfcs_pkg::PH_DESEL;
									end
								end
								sfcs_pkg::PH_TX: begin
									page_d  = pdec;
									left_d  = left_q - 1'b1;
									addr_d  = addr_q + 1'b1;
									phase_d = (pdec == '0) ? sfcs_pkg::PH_DESEL
										: sfcs_pkg::PH_WAIT;
								end
								default: begin
									// receive phase
									if (frame_q == sfcs_pkg::FR_POLL) begin
										phase_d = sfcs_pkg::PH_DESEL;
									end else begin
										rvalid  = 1'b1;
										rdata   = sh;
										phase_d = sfcs_pkg::PH_DESEL;
										if (frame_q == sfcs_pkg::FR_READ) begin
											left_d = left_q - 1'b1;
											addr_d = addr_q + 1'b1;
											if (left_q != sfcs_pkg::CNT_W'(1)) begin
												phase_d = sfcs_pkg::PH_RX;
												shreg_d = 8'h00;
											end
										end
									end
								end
							endcase
						end
					end
				end
			end
			default: begin
			end
		endcase

		if (new_frame) begin
			frame_d = nf;
			phase_d = sfcs_pkg::PH_HDR;
			hidx_d  = 3'd0;
			shreg_d = sfcs_pkg::hdr_byte(nf, 3'd0, addr_q);
			bit_d   = sfcs_pkg::BIT_MSB;
			half_d  = 1'b0;
		end

		res.sck        = sck_d;
		res.mosi       = mosi_d;
		res.cs_n       = csn_d;
		res.read_valid = rvalid;
		res.read_data  = rdata;
		res.need_data  = (phase_d == sfcs_pkg::PH_WAIT);
		res.busy_res   = (phase_d != sfcs_pkg::PH_IDLE);
		res.done_res   = done;
		res.cmd_error  = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfcs_pkg::PH_IDLE;
			frame_q <= sfcs_pkg::FR_ID;
			op_q    <= '0;
			addr_q  <= '0;
			left_q  <= '0;
			page_q  <= '0;
			shreg_q <= '0;
			bit_q   <= sfcs_pkg::BIT_MSB;
			half_q  <= 1'b0;
			hidx_q  <= '0;
			sck_q   <= 1'b0;
			mosi_q  <= 1'b1;
			csn_q   <= 1'b1;
		end else if (fire) begin
			phase_q <= phase_d;
			frame_q <= frame_d;
			op_q    <= op_d;
			addr_q  <= addr_d;
			left_q  <= left_d;
			page_q  <= page_d;
			shreg_q <= shreg_d;
			bit_q   <= bit_d;
			half_q  <= half_d;
			hidx_q  <= hidx_d;
			sck_q   <= sck_d;
			mosi_q  <= mosi_d;
			csn_q   <= csn_d;
		end
	end

endmodule

// ----- hw/rtl/spi_flash_command_sequencer.sv -----
// Top level of the SPI NOR flash command sequencer: input stage, sequencer, result register.
// Throughput: one beat per cycle on each side while the result side does not stall.
// A beat accepted is loaded into the input register; when it fires, its result is
// registered in the result register, from which it can leave.
// Rate is set by the single pass through the sequencer's next-state logic.
// Reset (arst_n low, asynchronous): both pipeline stages empty, sequencer idle with its
// pin registers at sck 0, mosi 1, cs_n 1; the result register itself is not reset.
module spi_flash_command_sequencer (
	input  logic                            clk,
	input  logic                            arst_n,
	// input beats
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      kind,
	input  logic [1:0]                      op,
	input  logic [sfcs_pkg::FADDR_W-1:0]    flash_address,
	input  logic [sfcs_pkg::CNT_W-1:0]      byte_count,
	input  logic [7:0]                      write_byte,
	input  logic                            miso,
	// result beats
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            sck,
	output logic                            mosi,
	output logic                            cs_n,
	output logic                            read_valid,
	output logic [7:0]                      read_data,
	output logic                            need_data,
	output logic                            busy_res,
	output logic                            done_res,
	output logic                            cmd_error
);

	sfcs_pkg::sfcs_item_t item_s1;
	logic                 v_s1;
	sfcs_pkg::sfcs_res_t  res;
	sfcs_pkg::sfcs_res_t  res_q;
	logic                 out_valid_q;
	logic                 out_adv;
	logic                 accept;
	logic                 fire;

	// The result register frees up when empty or when its beat leaves this cycle.
	// The input stage then hands its beat to the sequencer (fire), and can take a new
	// beat in the same cycle, so a steady stream moves one beat per clock.
	assign out_adv  = !out_valid_q || !out_stall;
	assign in_stall = v_s1 && !out_adv;
	assign accept   = in_valid && !in_stall;
	assign fire     = v_s1 && out_adv;

	// Input register: the captured beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept || (v_s1 && !out_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.kind          <= kind;
			item_s1.op            <= op;
			item_s1.flash_address <= flash_address;
			item_s1.byte_count    <= byte_count;
			item_s1.write_byte    <= write_byte;
			item_s1.miso          <= miso;
		end
	end

	// Sequencer: holds the command state; updates it only when a beat fires.
	sfcs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	// Result register: holds a finished beat while the far side stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= fire || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign sck        = res_q.sck;
	assign mosi       = res_q.mosi;
	assign cs_n       = res_q.cs_n;
	assign read_valid = res_q.read_valid;
	assign read_data  = res_q.read_data;
	assign need_data  = res_q.need_data;
	assign busy_res   = res_q.busy_res;
	assign done_res   = res_q.done_res;
	assign cmd_error  = res_q.cmd_error;

`ifndef NO_ASSERTIONS
	// Waiting for program data or showing a received byte only happens mid-command.
	a_busy_when_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (need_data || read_valid) |-> busy_res)
		else $error("need_data or read_valid outside a command");

	// A rejected start never also finishes a command.
	a_done_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(done_res && cmd_error))
		else $error("done and cmd_error on the same beat");

	// With no command running the bus is deselected and SCK is low.
	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !busy_res |-> cs_n && !sck && mosi)
		else $error("bus not idle while sequencer idle");
`endif

endmodule
